FILE: hdl/nic_descriptor_ring_tracker_assert.svh
// Assertion macros shared by the ring tracker RTL.
// Each macro names the clock and reset of the module that uses it.
`ifndef NIC_DESCRIPTOR_RING_TRACKER_ASSERT_SVH
`define NIC_DESCRIPTOR_RING_TRACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define NICDRT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nicdrt: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define NICDRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nicdrt: next-cycle check failed");

`endif

FILE: hdl/nicdrt_pkg.sv
`default_nettype none

package nicdrt_pkg;

  // Ring sizes
  localparam int unsigned RX_ENTRIES = 64;
  localparam int unsigned TX_ENTRIES = 16;
  localparam int unsigned RX_IDX_W   = $clog2(RX_ENTRIES);
  localparam int unsigned TX_IDX_W   = $clog2(TX_ENTRIES);

  // Statistics counters
  localparam int unsigned NSTAT  = 13;
  localparam int unsigned STAT_W = 32;
  localparam int unsigned SEL_W  = 4;

  localparam int unsigned STAT_RXBUFF = 0;
  localparam int unsigned STAT_CRC    = 1;
  localparam int unsigned STAT_OFLO   = 2;
  localparam int unsigned STAT_FRAM   = 3;
  localparam int unsigned STAT_RTRY   = 4;
  localparam int unsigned STAT_LCAR   = 5;
  localparam int unsigned STAT_LCOL   = 6;
  localparam int unsigned STAT_UFLO   = 7;
  localparam int unsigned STAT_TXBUFF = 8;
  localparam int unsigned STAT_MERR   = 9;
  localparam int unsigned STAT_MISS   = 10;
  localparam int unsigned STAT_BABL   = 11;
  localparam int unsigned STAT_OERRS  = 12;

  // Descriptor and status bits
  localparam int unsigned BIT_OWN      = 31;
  localparam int unsigned BIT_ERR_SUM  = 30;
  localparam int unsigned BIT_RX_BUFF  = 26;
  localparam int unsigned BIT_RX_CRC   = 27;
  localparam int unsigned BIT_RX_OFLO  = 28;
  localparam int unsigned BIT_RX_FRAM  = 29;
  localparam int unsigned BIT_TX_RTRY  = 26;
  localparam int unsigned BIT_TX_LCAR  = 27;
  localparam int unsigned BIT_TX_LCOL  = 28;
  localparam int unsigned BIT_TX_UFLO  = 30;
  localparam int unsigned BIT_TX_BUFF  = 31;
  localparam int unsigned BIT_SW_TX    = 9;
  localparam int unsigned BIT_SW_RX    = 10;
  localparam int unsigned BIT_SW_MERR  = 11;
  localparam int unsigned BIT_SW_MISS  = 12;
  localparam int unsigned BIT_SW_BABL  = 14;

  localparam logic [15:0] ACK_VALUE    = 16'h7E40;
  localparam logic [15:0] RX_ARM_HI    = 16'h8000;
  localparam logic [15:0] TX_FILL_HI   = 16'h8300;

  // Configuration registers
  localparam int unsigned PADDR_W = 3;
  localparam logic        REG_RX_BUFFER_BYTES = 1'b0;
  localparam logic [11:0] RX_BUFFER_BYTES_RST = 12'd1518;

  typedef enum logic [2:0] {
    ACT_STATUS    = 3'd0,
    ACT_RX_CHECK  = 3'd1,
    ACT_TX_OFFER  = 3'd2,
    ACT_TX_CHECK  = 3'd3,
    ACT_STAT_READ = 3'd4
  } action_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] status_word;
    logic [31:0] desc_status;
    logic [31:0] desc_count;
    logic [11:0] frame_length;
    logic [3:0]  stat_select;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [5:0]  ring_index;
    logic [31:0] write_back_word;
    logic        frame_good;
    logic [11:0] rx_length;
    logic        service_rx;
    logic        service_tx;
    logic [15:0] ack_word;
    logic [3:0]  tx_pending;
    logic [31:0] stat_value;
  } out_item_t;

endpackage

`default_nettype wire

FILE: hdl/nicdrt_stats.sv
`default_nettype none

module nicdrt_stats import nicdrt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [NSTAT-1:0]  bump_i,
  input  wire logic [SEL_W-1:0]  sel_i,
  output logic      [STAT_W-1:0] value_o
);

  logic [STAT_W-1:0] cnt_q [NSTAT];

  // Advance each counter whose event fired; wrap at full width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSTAT; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NSTAT; i++) begin
        if (bump_i[i]) begin
          cnt_q[i] <= cnt_q[i] + STAT_W'(1);
        end
      end
    end
  end

  // Read the selected counter; codes beyond the list read zero
  always_comb begin
    value_o = '0;
    for (int i = 0; i < NSTAT; i++) begin
      if (sel_i == SEL_W'(i)) begin
        value_o = cnt_q[i];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/nic_descriptor_ring_tracker.sv
// Descriptor ring tracker for an Ethernet receive ring and transmit ring.
// Input channel: in_valid_i / in_stall_o carry one event item (in_item_t):
// a status event, a receive descriptor check, a transmit offer, a transmit
// descriptor check or a statistic read. Output channel: out_valid_o /
// out_stall_i carry exactly one result item (out_item_t) per event.
// An item is taken at a rising edge with valid high and stall low.
// Each result is registered in the output register or the skid register.
// Throughput: one item per cycle while in_stall_o is low; ring indexes,
// pending count and the 13 statistics counters are updated in the cycle
// the item is taken, so the next item sees them at once.
// When the receiver stalls, the result is held in the output register and
// one further item is parked in a skid register; in_stall_o then rises
// until the output register drains.
// Reset (rst_ni low) clears indexes, pending count, counters and both
// buffer stages, and sets rx_buffer_bytes to 1518. The APB port writes
// rx_buffer_bytes at byte address 0; the user must write it only while the
// block is idle; the block does not enforce this. pready is always high.
`default_nettype none

module nic_descriptor_ring_tracker import nicdrt_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire in_item_t           in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_item_t               out_item_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  `include "nic_descriptor_ring_tracker_assert.svh"

  localparam logic [TX_IDX_W-1:0] TX_MAX_PENDING = TX_IDX_W'(TX_ENTRIES - 1);

  logic [11:0]         rx_buf_bytes_q;
  logic [RX_IDX_W-1:0] rx_index_q, rx_index_d;
  logic [TX_IDX_W-1:0] tx_head_q, tx_head_d;
  logic [TX_IDX_W-1:0] tx_tail_q, tx_tail_d;
  logic [TX_IDX_W-1:0] tx_count_q, tx_count_d;
  logic [NSTAT-1:0]    bump;
  logic [STAT_W-1:0]   stat_rd;
  logic                in_take;
  logic                out_pop;
  out_item_t           res;
  out_item_t           out_q, skid_q;
  logic                out_valid_q, skid_valid_q;
  logic [RX_IDX_W:0]   rx_inc;
  logic [TX_IDX_W:0]   head_inc, tail_inc;
  logic [11:0]         msg_cnt;

  // APB register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RX_BUFFER_BYTES) ? {20'd0, rx_buf_bytes_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_buf_bytes_q <= RX_BUFFER_BYTES_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_RX_BUFFER_BYTES) begin
      rx_buf_bytes_q <= pwdata[11:0];
    end
  end

  // Handshake: stall only while the skid stage holds an item
  assign in_stall_o = skid_valid_q;
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_pop    = out_valid_q && !out_stall_i;

  assign rx_inc   = {1'b0, rx_index_q} + (RX_IDX_W + 1)'(1);
  assign head_inc = {1'b0, tx_head_q} + (TX_IDX_W + 1)'(1);
  assign tail_inc = {1'b0, tx_tail_q} + (TX_IDX_W + 1)'(1);
  assign msg_cnt  = in_item_i.desc_count[11:0];

  // Decode one event: result fields, counter events, next ring state
  always_comb begin
    res        = '0;
    bump       = '0;
    rx_index_d = rx_index_q;
    tx_head_d  = tx_head_q;
    tx_tail_d  = tx_tail_q;
    tx_count_d = tx_count_q;
    case (in_item_i.action)
      ACT_STATUS: begin
        bump[STAT_MERR] = in_item_i.status_word[BIT_SW_MERR];
        bump[STAT_MISS] = in_item_i.status_word[BIT_SW_MISS];
        bump[STAT_BABL] = in_item_i.status_word[BIT_SW_BABL];
        res.service_rx  = in_item_i.status_word[BIT_SW_RX];
        res.service_tx  = in_item_i.status_word[BIT_SW_TX];
        res.ack_word    = ACK_VALUE;
      end
      ACT_RX_CHECK: begin
        res.ring_index = 6'(rx_index_q);
        if (!in_item_i.desc_status[BIT_OWN]) begin
          if (in_item_i.desc_status[BIT_ERR_SUM]) begin
            bump[STAT_RXBUFF] = in_item_i.desc_status[BIT_RX_BUFF];
            bump[STAT_CRC]    = in_item_i.desc_status[BIT_RX_CRC];
            bump[STAT_OFLO]   = in_item_i.desc_status[BIT_RX_OFLO];
            bump[STAT_FRAM]   = in_item_i.desc_status[BIT_RX_FRAM];
          end else begin
            res.frame_good = 1'b1;
            res.rx_length  = (msg_cnt >= 12'd4) ? msg_cnt - 12'd4 : 12'd0;
          end
          res.accepted        = 1'b1;
          res.write_back_word = {RX_ARM_HI, 16'd0 - {4'd0, rx_buf_bytes_q}};
          rx_index_d = (rx_inc >= (RX_IDX_W + 1)'(RX_ENTRIES)) ? '0 : rx_inc[RX_IDX_W-1:0];
        end
      end
      ACT_TX_OFFER: begin
        res.ring_index = 6'(tx_head_q);
        if (tx_count_q < TX_MAX_PENDING) begin
          res.accepted        = 1'b1;
          res.write_back_word = {TX_FILL_HI, 16'd0 - {4'd0, in_item_i.frame_length}};
          tx_count_d = tx_count_q + TX_IDX_W'(1);
          tx_head_d  = (head_inc >= (TX_IDX_W + 1)'(TX_ENTRIES)) ? '0 : head_inc[TX_IDX_W-1:0];
        end
      end
      ACT_TX_CHECK: begin
        res.ring_index = 6'(tx_tail_q);
        if (tx_count_q != '0 && !in_item_i.desc_status[BIT_OWN]) begin
          if (in_item_i.desc_status[BIT_ERR_SUM]) begin
            bump[STAT_RTRY]   = in_item_i.desc_count[BIT_TX_RTRY];
            bump[STAT_LCAR]   = in_item_i.desc_count[BIT_TX_LCAR];
            bump[STAT_LCOL]   = in_item_i.desc_count[BIT_TX_LCOL];
            bump[STAT_UFLO]   = in_item_i.desc_count[BIT_TX_UFLO];
            bump[STAT_TXBUFF] = in_item_i.desc_count[BIT_TX_BUFF];
            bump[STAT_OERRS]  = 1'b1;
          end
          res.accepted = 1'b1;
          tx_count_d = tx_count_q - TX_IDX_W'(1);
          tx_tail_d  = (tail_inc >= (TX_IDX_W + 1)'(TX_ENTRIES)) ? '0 : tail_inc[TX_IDX_W-1:0];
        end
      end
      ACT_STAT_READ: begin
        res.stat_value = stat_rd;
      end
      default: begin
      end
    endcase
    res.tx_pending = 4'(tx_count_d);
  end

  nicdrt_stats u_stats (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .bump_i  (in_take ? bump : '0),
    .sel_i   (in_item_i.stat_select),
    .value_o (stat_rd)
  );

  // Commit ring state when an item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_index_q <= '0;
      tx_head_q  <= '0;
      tx_tail_q  <= '0;
      tx_count_q <= '0;
    end else if (in_take) begin
      rx_index_q <= rx_index_d;
      tx_head_q  <= tx_head_d;
      tx_tail_q  <= tx_tail_d;
      tx_count_q <= tx_count_d;
    end
  end

  // Output register and skid stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_pop) begin
      out_valid_q  <= skid_valid_q || in_take;
      skid_valid_q <= 1'b0;
    end else if (in_take) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output register and skid stage payload
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_pop) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_take) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  `NICDRT_ASSERT_NOW(a_pending_bound, 1'b1, tx_count_q <= TX_MAX_PENDING)
  `NICDRT_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q)
  `NICDRT_ASSERT_NEXT(a_out_held, out_valid_q && out_stall_i, out_valid_q)
  `NICDRT_ASSERT_NEXT(a_offer_counts,
      in_take && in_item_i.action == ACT_TX_OFFER && tx_count_q < TX_MAX_PENDING,
      tx_count_q == $past(tx_count_q) + TX_IDX_W'(1))

endmodule

`default_nettype wire
